// ===== src/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants for the bilinear image scaler: field widths, register
// indexes, reset values and queue depths.
// ----------------------------------------------------------------------------
package bis_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_SOURCE_WIDTH  = 256;
   localparam int DEF_MAX_SOURCE_HEIGHT = 256;
   localparam int DEF_FRACTION_BITS     = 16;

   // fixed field widths
   localparam int COORD_W  = 12;
   localparam int PIXEL_W  = 24;
   localparam int CH_W     = 8;
   localparam int CH_COUNT = 3;
   localparam int DIM_W    = 9;
   localparam int STEP_W   = 24;
   localparam int STEP_FRAC = 16;
   localparam int POS_W    = COORD_W + STEP_W;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_X        = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_Y        = 2'd3;

   localparam logic [DIM_W-1:0]  RESET_SOURCE_WIDTH  = 9'd256;
   localparam logic [DIM_W-1:0]  RESET_SOURCE_HEIGHT = 9'd256;
   localparam logic [STEP_W-1:0] RESET_STEP          = 24'd65536;

   // operation codes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // queue between front and back, and result buffer
   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 2;

endpackage

// ===== src/bis_ram.sv =====
// ----------------------------------------------------------------------------
// bis_ram
// Generic single-port RAM, one write or one read a cycle, registered read.
// ----------------------------------------------------------------------------
module bis_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bis_fifo.sv =====
// ----------------------------------------------------------------------------
// bis_fifo
// Small synchronous queue of any item type, valid/ready on both sides.
// ----------------------------------------------------------------------------
module bis_fifo #(
   parameter int  DEPTH = 4,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   item_type        slots_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/bis_front.sv =====
// ----------------------------------------------------------------------------
// bis_front
// Accepts items, multiplies the coordinates by the steps, classifies loads
// and requests, clamps neighbour indices and hands jobs to the queue.
// ----------------------------------------------------------------------------
module bis_front #(
   parameter int  MAX_SOURCE_WIDTH  = 256,
   parameter int  MAX_SOURCE_HEIGHT = 256,
   parameter int  FRACTION_BITS     = 16,
   parameter type job_type          = logic
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [bis_pkg::COORD_W-1:0]   req_column,
   input  logic [bis_pkg::COORD_W-1:0]   req_row,
   input  logic [bis_pkg::PIXEL_W-1:0]   req_pixel_in,
   input  logic [bis_pkg::DIM_W-1:0]     source_width,
   input  logic [bis_pkg::DIM_W-1:0]     source_height,
   input  logic [bis_pkg::STEP_W-1:0]    step_x,
   input  logic [bis_pkg::STEP_W-1:0]    step_y,
   output logic                          push_valid,
   input  logic                          push_ready,
   output job_type                       push_data
);

   import bis_pkg::*;

   localparam int XW   = $clog2(MAX_SOURCE_WIDTH);
   localparam int YW   = $clog2(MAX_SOURCE_HEIGHT);
   localparam int AW   = $clog2(MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT);
   localparam int LW   = COORD_W + 1;
   localparam int IP_W = POS_W - STEP_FRAC;

   localparam logic [LW-1:0] MAX_X = LW'(MAX_SOURCE_WIDTH);
   localparam logic [LW-1:0] MAX_Y = LW'(MAX_SOURCE_HEIGHT);

   logic                  valid_ff;
   logic                  op_ff;
   logic [COORD_W-1:0]    col_ff;
   logic [COORD_W-1:0]    row_ff;
   logic [PIXEL_W-1:0]    pix_ff;
   logic [POS_W-1:0]      pos_x_ff;
   logic [POS_W-1:0]      pos_y_ff;
   logic [POS_W-1:0]      pos_x_in;
   logic [POS_W-1:0]      pos_y_in;

   logic [LW-1:0]         wid_ext;
   logic [LW-1:0]         hgt_ext;
   logic [LW-1:0]         last_x_ext;
   logic [LW-1:0]         last_y_ext;
   logic [XW-1:0]         last_x;
   logic [YW-1:0]         last_y;
   logic [IP_W-1:0]       ip_x;
   logic [IP_W-1:0]       ip_y;
   logic [XW-1:0]         x0;
   logic [YW-1:0]         y0;
   logic                  load_ok;
   logic                  drop;
   logic                  advance;
   logic                  accept;

   assign accept   = req_valid && req_ready;
   assign pos_x_in = req_column * step_x;
   assign pos_y_in = req_row * step_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         col_ff   <= req_column;
         row_ff   <= req_row;
         pix_ff   <= req_pixel_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   // dimensions saturated to 2 .. max, then last index
   always_comb begin
      wid_ext = LW'(source_width);
      hgt_ext = LW'(source_height);
      if (wid_ext < LW'(2)) begin
         last_x_ext = LW'(1);
      end else if (wid_ext > MAX_X) begin
         last_x_ext = MAX_X - 1'b1;
      end else begin
         last_x_ext = wid_ext - 1'b1;
      end
      if (hgt_ext < LW'(2)) begin
         last_y_ext = LW'(1);
      end else if (hgt_ext > MAX_Y) begin
         last_y_ext = MAX_Y - 1'b1;
      end else begin
         last_y_ext = hgt_ext - 1'b1;
      end
   end

   assign last_x = last_x_ext[XW-1:0];
   assign last_y = last_y_ext[YW-1:0];
   assign ip_x   = pos_x_ff[POS_W-1:STEP_FRAC];
   assign ip_y   = pos_y_ff[POS_W-1:STEP_FRAC];
   assign x0     = (ip_x > IP_W'(last_x)) ? last_x : ip_x[XW-1:0];
   assign y0     = (ip_y > IP_W'(last_y)) ? last_y : ip_y[YW-1:0];

   // loads outside the store are dropped here
   assign load_ok = ({1'b0, col_ff} < MAX_X) && ({1'b0, row_ff} < MAX_Y);
   assign drop    = (op_ff == OP_LOAD) && !load_ok;
   assign advance = valid_ff && (drop || push_ready);

   assign req_ready  = !valid_ff || advance;
   assign push_valid = valid_ff && !drop;

   always_comb begin
      push_data       = '0;
      push_data.load  = (op_ff == OP_LOAD);
      push_data.addr  = AW'(row_ff[YW-1:0]) * AW'(MAX_SOURCE_WIDTH) + AW'(col_ff[XW-1:0]);
      push_data.pixel = pix_ff;
      push_data.x0    = x0;
      push_data.x1    = (x0 < last_x) ? XW'(x0 + 1'b1) : last_x;
      push_data.y0    = y0;
      push_data.y1    = (y0 < last_y) ? YW'(y0 + 1'b1) : last_y;
      push_data.fx    = pos_x_ff[STEP_FRAC-1 -: FRACTION_BITS];
      push_data.fy    = pos_y_ff[STEP_FRAC-1 -: FRACTION_BITS];
   end

endmodule

// ===== src/bis_back.sv =====
// ----------------------------------------------------------------------------
// bis_back
// Owns the source store: writes loads, reads the four neighbours of a
// request in turn, blends each channel and buffers the result.
// ----------------------------------------------------------------------------
module bis_back #(
   parameter int  MAX_SOURCE_WIDTH  = 256,
   parameter int  MAX_SOURCE_HEIGHT = 256,
   parameter int  FRACTION_BITS     = 16,
   parameter type job_type          = logic
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  job_type                       job,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bis_pkg::PIXEL_W-1:0]   rsp_color_out
);

   import bis_pkg::*;

   localparam int XW      = $clog2(MAX_SOURCE_WIDTH);
   localparam int YW      = $clog2(MAX_SOURCE_HEIGHT);
   localparam int DEPTH   = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
   localparam int AW      = $clog2(DEPTH);
   localparam int HSUM_W  = CH_W + FRACTION_BITS;
   localparam int HPROD_W = HSUM_W + 1;
   localparam int VPROD_W = CH_W + 2 * FRACTION_BITS + 1;
   localparam int PEND_W  = $clog2(OUT_DEPTH + 1);

   localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [1:0]              phase_ff, phase_in;
   job_type                 job_ff;
   logic                    rd_valid_ff;
   logic [1:0]              rd_phase_ff;
   logic [PIXEL_W-1:0]      first_ff;
   logic [HSUM_W-1:0]       top_ff [CH_COUNT];
   logic [HSUM_W-1:0]       bot_ff [CH_COUNT];
   logic [FRACTION_BITS-1:0] fy_ff;
   logic                    blend_valid_ff;
   logic [PEND_W-1:0]       pending_ff;

   logic                    issue_load;
   logic                    issue_req;
   logic                    rd_en;
   logic [1:0]              cur_phase;
   logic [XW-1:0]           sel_x;
   logic [YW-1:0]           sel_y;
   logic [AW-1:0]           ram_addr;
   logic [PIXEL_W-1:0]      rd_data;
   logic [FRACTION_BITS:0]  wx;
   logic [FRACTION_BITS:0]  wy;
   logic [HPROD_W-1:0]      hprod [CH_COUNT];
   logic [VPROD_W-1:0]      vprod [CH_COUNT];
   logic [PIXEL_W-1:0]      color;
   logic                    out_ready;
   logic                    rsp_take;

   // ---- sequencer ----
   assign issue_load = (state_ff == ST_IDLE) && job_valid && job.load;
   assign issue_req  = (state_ff == ST_IDLE) && job_valid && !job.load &&
                       (pending_ff < PEND_W'(OUT_DEPTH));
   assign job_ready  = issue_load || issue_req;
   assign rd_en      = issue_req || (state_ff == ST_READ);
   assign cur_phase  = (state_ff == ST_READ) ? phase_ff : 2'd0;

   // neighbour order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
   always_comb begin
      if (state_ff == ST_READ) begin
         sel_x = phase_ff[0] ? job_ff.x1 : job_ff.x0;
         sel_y = phase_ff[1] ? job_ff.y1 : job_ff.y0;
      end else begin
         sel_x = job.x0;
         sel_y = job.y0;
      end
      if (issue_load) begin
         ram_addr = job.addr;
      end else begin
         ram_addr = AW'(sel_y) * AW'(MAX_SOURCE_WIDTH) + AW'(sel_x);
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (issue_req) begin
               state_in = ST_READ;
               phase_in = 2'd1;
            end
         end
         ST_READ: begin
            phase_in = phase_ff + 1'b1;
            if (phase_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            phase_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= 2'd0;
         rd_valid_ff    <= 1'b0;
         blend_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         rd_valid_ff    <= rd_en;
         blend_valid_ff <= rd_valid_ff && (rd_phase_ff == 2'd3);
      end
   end

   // requests in flight or waiting in the result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (issue_req && !rsp_take) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (rsp_take && !issue_req) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_req) begin
         job_ff <= job;
      end
      rd_phase_ff <= cur_phase;
   end

   bis_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock    (clock),
      .write_en (issue_load),
      .addr     (ram_addr),
      .wr_data  (job.pixel),
      .rd_data  (rd_data)
   );

   // ---- horizontal blend, one pair of neighbours at a time ----
   assign wx = ONE - {1'b0, job_ff.fx};

   always_comb begin
      for (int c = 0; c < CH_COUNT; c++) begin
         hprod[c] = HPROD_W'(first_ff[c*CH_W +: CH_W]) * HPROD_W'(wx) +
                    HPROD_W'(rd_data[c*CH_W +: CH_W]) * HPROD_W'(job_ff.fx);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         if (!rd_phase_ff[0]) begin
            first_ff <= rd_data;
         end
         if (rd_phase_ff == 2'd1) begin
            for (int c = 0; c < CH_COUNT; c++) begin
               top_ff[c] <= hprod[c][HSUM_W-1:0];
            end
         end
         if (rd_phase_ff == 2'd3) begin
            for (int c = 0; c < CH_COUNT; c++) begin
               bot_ff[c] <= hprod[c][HSUM_W-1:0];
            end
            fy_ff <= job_ff.fy;
         end
      end
   end

   // ---- vertical blend and truncation ----
   assign wy = ONE - {1'b0, fy_ff};

   always_comb begin
      for (int c = 0; c < CH_COUNT; c++) begin
         vprod[c] = VPROD_W'(top_ff[c]) * VPROD_W'(wy) +
                    VPROD_W'(bot_ff[c]) * VPROD_W'(fy_ff);
         color[c*CH_W +: CH_W] = vprod[c][2*FRACTION_BITS +: CH_W];
      end
   end

   // buffer space is reserved at issue, so out_ready is always high here
   bis_fifo #(
      .DEPTH     (OUT_DEPTH),
      .item_type (logic [PIXEL_W-1:0])
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (blend_valid_ff && out_ready),
      .push_ready (out_ready),
      .push_data  (color),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_color_out)
   );

   assign rsp_take = rsp_valid && rsp_ready;

endmodule

// ===== src/bilinear_image_scaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Stores a source image and returns bilinearly scaled destination pixels.
//
//   channel  ports  handshake     payload
//   input    req_   valid/ready   operation, column, row, pixel_in
//   result   rsp_   valid/ready   color_out
//   config   csr_   write strobe  index, data (no read-back)
//
// A load takes a single write on the store port; a request takes one read
// per neighbour on the single-port source store, and the back takes no new
// item until those four reads are done. The front holds one item, a 4-entry
// queue sits between front and back, and the back keeps room for 2 results,
// so either side can stall alone. The source store has no reset and no
// clearing pass.
// ----------------------------------------------------------------------------
module bilinear_image_scaler #(
   parameter int MAX_SOURCE_WIDTH  = bis_pkg::DEF_MAX_SOURCE_WIDTH,
   parameter int MAX_SOURCE_HEIGHT = bis_pkg::DEF_MAX_SOURCE_HEIGHT,
   parameter int FRACTION_BITS     = bis_pkg::DEF_FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [bis_pkg::COORD_W-1:0]       req_column,
   input  logic [bis_pkg::COORD_W-1:0]       req_row,
   input  logic [bis_pkg::PIXEL_W-1:0]       req_pixel_in,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bis_pkg::PIXEL_W-1:0]       rsp_color_out,

   input  logic                              csr_write,
   input  logic [bis_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bis_pkg::CSR_DATA_W-1:0]    csr_data
);

   import bis_pkg::*;

   localparam int XW = $clog2(MAX_SOURCE_WIDTH);
   localparam int YW = $clog2(MAX_SOURCE_HEIGHT);
   localparam int AW = $clog2(MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT);

   typedef struct packed {
      logic                     load;
      logic [AW-1:0]            addr;
      logic [PIXEL_W-1:0]       pixel;
      logic [XW-1:0]            x0;
      logic [XW-1:0]            x1;
      logic [YW-1:0]            y0;
      logic [YW-1:0]            y1;
      logic [FRACTION_BITS-1:0] fx;
      logic [FRACTION_BITS-1:0] fy;
   } job_type;

   logic [DIM_W-1:0]  source_width_ff;
   logic [DIM_W-1:0]  source_height_ff;
   logic [STEP_W-1:0] step_x_ff;
   logic [STEP_W-1:0] step_y_ff;

   logic    push_valid;
   logic    push_ready;
   job_type push_data;
   logic    job_valid;
   logic    job_ready;
   job_type job;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= RESET_SOURCE_WIDTH;
         source_height_ff <= RESET_SOURCE_HEIGHT;
         step_x_ff        <= RESET_STEP;
         step_y_ff        <= RESET_STEP;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_data[DIM_W-1:0];
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_data[DIM_W-1:0];
            CSR_STEP_X:        step_x_ff        <= csr_data[STEP_W-1:0];
            CSR_STEP_Y:        step_y_ff        <= csr_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   bis_front #(
      .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
      .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
      .FRACTION_BITS     (FRACTION_BITS),
      .job_type          (job_type)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_column    (req_column),
      .req_row       (req_row),
      .req_pixel_in  (req_pixel_in),
      .source_width  (source_width_ff),
      .source_height (source_height_ff),
      .step_x        (step_x_ff),
      .step_y        (step_y_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   bis_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (job_type)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_data   (job)
   );

   bis_back #(
      .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
      .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
      .FRACTION_BITS     (FRACTION_BITS),
      .job_type          (job_type)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job_ready     (job_ready),
      .job           (job),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_color_out (rsp_color_out)
   );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear image scaler. Source pixels are loaded
// on demand so that no request reads an unwritten store entry. Each accepted
// request is scored against a local fixed-point interpolator. The sender
// works in random bursts and the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module testbench;
   import bis_pkg::*;

   localparam int MAX_W          = DEF_MAX_SOURCE_WIDTH;
   localparam int MAX_H          = DEF_MAX_SOURCE_HEIGHT;
   localparam int FRAC_BITS      = DEF_FRACTION_BITS;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SELDOM,
      READY_PERIODIC
   } ready_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_operation = OP_LOAD;
   logic [COORD_W-1:0]     req_column = '0;
   logic [COORD_W-1:0]     req_row = '0;
   logic [PIXEL_W-1:0]     req_pixel_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PIXEL_W-1:0]     rsp_color_out;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SOURCE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // local copy of the source image and the registers
   logic [PIXEL_W-1:0] image_mem [0:MAX_W*MAX_H-1];
   bit                 image_written [0:MAX_W*MAX_H-1];
   logic [DIM_W-1:0]   cfg_width = RESET_SOURCE_WIDTH;
   logic [DIM_W-1:0]   cfg_height = RESET_SOURCE_HEIGHT;
   logic [STEP_W-1:0]  cfg_step_x = RESET_STEP;
   logic [STEP_W-1:0]  cfg_step_y = RESET_STEP;

   logic [PIXEL_W-1:0] color_expected [$];
   logic [PIXEL_W-1:0] color_want;
   int                 error_count = 0;
   int                 items_sent = 0;
   int                 burst_left = 0;
   int                 idle_cycles = 0;
   ready_mode_type     ready_mode = READY_ALWAYS;
   int                 mode_left = 0;
   int                 pattern_count = 0;

   bilinear_image_scaler DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_column    (req_column),
      .req_row       (req_row),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_color_out (rsp_color_out),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw, input int maxv);
      if (raw < 2) return 2;
      if (raw > maxv) return maxv;
      return 32'(raw);
   endfunction

   // source position of one coordinate: two clamped neighbours and a weight
   function automatic void locate(input logic [COORD_W-1:0] coord,
                                  input logic [STEP_W-1:0] step,
                                  input int unsigned dim,
                                  output int unsigned i0,
                                  output int unsigned i1,
                                  output longint unsigned weight);
      logic [POS_W-1:0] pos;
      logic [POS_W-STEP_FRAC-1:0] whole;
      int unsigned last;
      pos = POS_W'(coord) * POS_W'(step);
      whole = pos[POS_W-1:STEP_FRAC];
      last = dim - 1;
      i0 = (whole > last) ? last : 32'(whole);
      i1 = (i0 < last) ? i0 + 1 : last;
      weight = longint'(pos[STEP_FRAC-1:0]) >> (STEP_FRAC - FRAC_BITS);
   endfunction

   function automatic logic [PIXEL_W-1:0] scale_pixel(input logic [COORD_W-1:0] col,
                                                       input logic [COORD_W-1:0] row);
      int unsigned x0, x1, y0, y1;
      longint unsigned fx, fy, one, upper, lower, blend;
      logic [PIXEL_W-1:0] p00, p10, p01, p11, color;
      locate(col, cfg_step_x, clamp_dim(cfg_width, MAX_W), x0, x1, fx);
      locate(row, cfg_step_y, clamp_dim(cfg_height, MAX_H), y0, y1, fy);
      p00 = image_mem[y0*MAX_W + x0];
      p10 = image_mem[y0*MAX_W + x1];
      p01 = image_mem[y1*MAX_W + x0];
      p11 = image_mem[y1*MAX_W + x1];
      one = longint'(1) << FRAC_BITS;
      color = '0;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         upper = p00[ch*CH_W +: CH_W] * (one - fx) + p10[ch*CH_W +: CH_W] * fx;
         lower = p01[ch*CH_W +: CH_W] * (one - fx) + p11[ch*CH_W +: CH_W] * fx;
         blend = (upper * (one - fy) + lower * fy) >> (2 * FRAC_BITS);
         color[ch*CH_W +: CH_W] = blend[CH_W-1:0];
      end
      return color;
   endfunction

   function automatic logic [STEP_W-1:0] step_for(input int dim, input int dest);
      return STEP_W'(((dim - 1) << STEP_FRAC) / dest);
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   // one item through the input channel; valid stays up inside a burst
   task automatic send_item(input logic op, input int col, input int row,
                            input logic [PIXEL_W-1:0] pix);
      int gap;
      logic [COORD_W-1:0] col_bits;
      logic [COORD_W-1:0] row_bits;
      col_bits = COORD_W'(col);
      row_bits = COORD_W'(row);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_column    <= col_bits;
      req_row       <= row_bits;
      req_pixel_in  <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (op == OP_LOAD) begin
         if (int'(col_bits) < MAX_W && int'(row_bits) < MAX_H) begin
            image_mem[int'(row_bits)*MAX_W + int'(col_bits)] = pix;
            image_written[int'(row_bits)*MAX_W + int'(col_bits)] = 1'b1;
         end
      end else begin
         color_expected.push_back(scale_pixel(col_bits, row_bits));
      end
   endtask

   // loads any neighbour not yet written, then asks for the pixel
   task automatic request_pixel(input int col, input int row);
      int unsigned x0, x1, y0, y1;
      longint unsigned fx, fy;
      int unsigned cx [4];
      int unsigned cy [4];
      locate(COORD_W'(col), cfg_step_x, clamp_dim(cfg_width, MAX_W), x0, x1, fx);
      locate(COORD_W'(row), cfg_step_y, clamp_dim(cfg_height, MAX_H), y0, y1, fy);
      cx = '{x0, x1, x0, x1};
      cy = '{y0, y0, y1, y1};
      for (int k = 0; k < 4; k++)
         if (!image_written[cy[k]*MAX_W + cx[k]])
            send_item(OP_LOAD, int'(cx[k]), int'(cy[k]), pick_pixel());
      send_item(OP_REQUEST, col, row, pick_pixel());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (color_expected.size() != 0) @(posedge clock);
      // loads may still sit in the block's queue
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] width_data, height_data,
                            input logic [CSR_DATA_W-1:0] step_x_data, step_y_data);
      drain();
      csr_put(CSR_SOURCE_WIDTH, width_data);
      csr_put(CSR_SOURCE_HEIGHT, height_data);
      csr_put(CSR_STEP_X, step_x_data);
      csr_put(CSR_STEP_Y, step_y_data);
      csr_write  <= 1'b0;
      cfg_width  = width_data[DIM_W-1:0];
      cfg_height = height_data[DIM_W-1:0];
      cfg_step_x = step_x_data;
      cfg_step_y = step_y_data;
   endtask

   task automatic run_phase(input int width_data, height_data,
                            input logic [CSR_DATA_W-1:0] step_x_data, step_y_data,
                            input int dest_w, dest_h, item_count);
      int stop_at;
      int pick;
      int w, h;
      configure(CSR_DATA_W'(width_data), CSR_DATA_W'(height_data), step_x_data, step_y_data);
      w = clamp_dim(cfg_width, MAX_W);
      h = clamp_dim(cfg_height, MAX_H);
      stop_at = items_sent + item_count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            request_pixel($urandom_range(0, dest_w - 1), $urandom_range(0, dest_h - 1));
         else if (pick < 80)
            request_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
         else if (pick < 90)
            send_item(OP_LOAD, $urandom_range(0, w - 1), $urandom_range(0, h - 1), pick_pixel());
         else if (pick < 95)
            send_item(OP_LOAD, $urandom_range(0, MAX_W - 1), $urandom_range(0, MAX_H - 1),
                      pick_pixel());
         else
            send_item(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095), pick_pixel());
      end
   endtask

   task automatic test_reset_defaults();
      send_item(OP_LOAD, 0, 0, 24'h000000);
      send_item(OP_LOAD, 1, 0, 24'hFFFFFF);
      send_item(OP_LOAD, 0, 1, 24'hFFFFFF);
      send_item(OP_LOAD, 1, 1, 24'h000000);
      request_pixel(0, 0);
      send_item(OP_LOAD, MAX_W - 1, MAX_H - 1, 24'hFFFFFF);
      request_pixel(MAX_W - 1, MAX_H - 1);
      request_pixel(1, 0);
   endtask

   task automatic test_edge_cases();
      // loads past the store are dropped
      send_item(OP_LOAD, 4095, 4095, 24'hABCDEF);
      send_item(OP_LOAD, MAX_W, 0, 24'h123456);
      send_item(OP_LOAD, 0, MAX_H, 24'h654321);
      // upper data bits beyond the register are discarded
      configure(24'hFFFE02, 24'h000002, 24'h008000, 24'h008000);
      request_pixel(1, 1);
      request_pixel(4095, 4095);
      // dimensions below and above range saturate
      configure(24'h000000, 24'h0001FF, 24'hFFFFFF, 24'h000000);
      request_pixel(4095, 4095);
      request_pixel(1, 0);
      request_pixel(0, 4095);
      configure(24'h000001, 24'h000101, 24'h000000, 24'h000001);
      request_pixel(4095, 4095);
      request_pixel(0, 0);
   endtask

   task automatic test_upscale();
      run_phase(2, 2, step_for(2, 7), step_for(2, 5), 7, 5, 110);
      run_phase(5, 3, step_for(5, 17), step_for(3, 11), 17, 11, 110);
      run_phase(12, 9, step_for(12, 40), step_for(9, 30), 40, 30, 110);
   endtask

   task automatic test_downscale();
      run_phase(256, 3, step_for(256, 37), step_for(3, 2), 37, 2, 110);
      run_phase(64, 64, step_for(64, 9), step_for(64, 9), 9, 9, 110);
      run_phase(3, 256, step_for(3, 2), step_for(256, 50), 2, 50, 110);
   endtask

   task automatic test_extreme_config();
      run_phase(0, 1, 24'hFFFFFF, 24'h000000, 4096, 4096, 90);
      run_phase(511, 257, 24'h000001, 24'hFFFFFF, 4096, 4096, 90);
      run_phase(256, 256, RESET_STEP, RESET_STEP, 256, 256, 90);
   endtask

   // receiver stalls, switching to a randomly chosen pattern when mode_left runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         pattern_count <= pattern_count + 1;
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            READY_SELDOM: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_ready <= (pattern_count % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (color_expected.size() == 0) begin
            $error("color_out: no result expected, actual %06h", rsp_color_out);
            error_count++;
         end else begin
            color_want = color_expected.pop_front();
            if (rsp_color_out !== color_want) begin
               $error("color_out mismatch: expected %06h, actual %06h", color_want, rsp_color_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL bilinear_image_scaler");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_edge_cases();
      test_upscale();
      test_downscale();
      test_extreme_config();
      drain();
      if (error_count == 0)
         $display("PASS bilinear_image_scaler");
      else
         $display("FAIL bilinear_image_scaler");
      $finish;
   end

endmodule
